[src/scsc_pkg.sv]
package scsc_pkg;

   localparam int MaxPoints  = 1024;
   localparam int MaxColumns = 1024;
   localparam int MaxEntries = 4096;

   localparam int PtW  = $clog2(MaxPoints);
   localparam int ColW = $clog2(MaxColumns + 1);
   localparam int CntW = $clog2(MaxEntries + 1);
   localparam int SlotW = 12;

   typedef enum logic [2:0] {
      OP_CLEAR = 3'd0,
      OP_LOAD  = 3'd1,
      OP_COUNT = 3'd2,
      OP_PREFIX = 3'd3,
      OP_PLACE = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   localparam logic [1:0] CSR_ROW_SCALE = 2'd0;
   localparam logic [1:0] CSR_COL_SCALE = 2'd1;
   localparam logic [1:0] CSR_SEL_COLS  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARKS,
      ST_ENTRY,
      ST_CLEAR,
      ST_PREFIX,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]        operation;
      logic [9:0]        point;
      logic signed [11:0] row_mark;
      logic signed [11:0] col_mark;
      logic [9:0]        entry_row;
      logic [9:0]        entry_col;
      logic [63:0]       entry_value;
      logic [10:0]       column_index;
   } req_type;

   typedef struct packed {
      logic        selected;
      logic [11:0] slot;
      logic [9:0]  sub_row;
      logic [63:0] value_out;
      logic [12:0] start_offset;
      logic [12:0] max_column_count;
      logic        overflow;
   } rsp_type;

endpackage

[src/scsc_ram.sv]
module scsc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[src/sparse_csr_to_csc_submatrix_top.sv]
// csr to csc submatrix extractor. one item in, one result out, one item in
// flight at a time. after reset the block sweeps both count memories to zero,
// one word a cycle, and holds req_stall until the sweep ends. load marks and
// the unused operations pass through the done state, count and place through
// the marks state (mark reads), then the entry state (a read-modify-write of
// the start or cursor memory), read start through the read state. clear
// sweeps both count memories, one word a cycle; prefix walks the start memory
// one column a cycle over selected_columns, clamped to MAX_COLUMNS. entries at
// index 0 of the start memory are kept zero. a new item is taken only when the
// output register is empty or its result leaves in the same cycle.
module sparse_csr_to_csc_submatrix_top
   import scsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   // configuration
   logic [1:0]  row_scale_ff, col_scale_ff;
   logic [10:0] sel_cols_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         row_scale_ff <= 2'b01;
         col_scale_ff <= 2'b01;
         sel_cols_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_SCALE: row_scale_ff <= csr_wdata[1:0];
            CSR_COL_SCALE: col_scale_ff <= csr_wdata[1:0];
            CSR_SEL_COLS:  sel_cols_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // memories
   logic             mk_we;
   logic [PtW-1:0]   rm_ra, cm_ra;
   logic [11:0]      rm_rd, cm_rd;
   logic             st_we, cu_we;
   logic [ColW-1:0]  st_wa, st_ra;
   logic [CntW-1:0]  st_wd, st_rd, cu_wd, cu_rd;
   logic [ColW-2:0]  cu_wa, cu_ra;
   req_type          req_ff, req_in;

   scsc_ram #(.Width(12), .Depth(MaxPoints)) u_row_marks (
      .clock, .wr_en(mk_we), .wr_addr(req_ff.point[PtW-1:0]),
      .wr_data(req_ff.row_mark), .rd_addr(rm_ra), .rd_data(rm_rd));
   scsc_ram #(.Width(12), .Depth(MaxPoints)) u_col_marks (
      .clock, .wr_en(mk_we), .wr_addr(req_ff.point[PtW-1:0]),
      .wr_data(req_ff.col_mark), .rd_addr(cm_ra), .rd_data(cm_rd));
   scsc_ram #(.Width(CntW), .Depth(MaxColumns + 1)) u_starts (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));
   scsc_ram #(.Width(CntW), .Depth(MaxColumns)) u_cursors (
      .clock, .wr_en(cu_we), .wr_addr(cu_wa), .wr_data(cu_wd),
      .rd_addr(cu_ra), .rd_data(cu_rd));

   assign rm_ra = req_data.entry_row[PtW-1:0];
   assign cm_ra = req_data.entry_col[PtW-1:0];

   // control
   state_type       state_ff, state_in;
   logic [ColW:0]   idx_ff, idx_in;
   logic [CntW-1:0] prev_ff, prev_in, largest_ff, largest_in;
   logic            ovf_ff, ovf_in;
   logic [ColW-1:0] col_ff, col_in;
   logic            sel_ff, sel_in;
   logic [9:0]      subrow_ff, subrow_in;
   logic            out_v_ff, out_v_in;
   rsp_type         out_ff, out_in;
   logic            init_ff, init_in;
   logic [ColW-1:0] ncols;

   assign ncols = (sel_cols_ff > 11'(MaxColumns)) ? ColW'(MaxColumns) : ColW'(sel_cols_ff);

   // mark decode, combinational on registered mark reads
   logic signed [13:0] rprod, cprod;
   logic               r_ok, c_ok, c_big;
   logic [11:0]        rmag;
   always_comb begin
      rprod = 14'(signed'(rm_rd)) * 14'(signed'(row_scale_ff));
      cprod = 14'(signed'(cm_rd)) * 14'(signed'(col_scale_ff));
      r_ok  = rprod > 0;
      c_ok  = cprod > 0;
      c_big = cprod > 14'(MaxColumns);
      rmag  = rm_rd[11] ? 12'(-rm_rd) : rm_rd;
   end

   assign req_stall = !(state_ff == ST_IDLE && (!out_v_ff || !rsp_stall));
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         // sweep the count memories before the first item
         state_ff   <= ST_CLEAR;
         idx_ff     <= '0;
         init_ff    <= 1'b1;
         out_v_ff   <= 1'b0;
         largest_ff <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         init_ff    <= init_in;
         out_v_ff   <= out_v_in;
         largest_ff <= largest_in;
         ovf_ff     <= ovf_in;
      end
      req_ff    <= req_in;
      prev_ff   <= prev_in;
      col_ff    <= col_in;
      sel_ff    <= sel_in;
      subrow_ff <= subrow_in;
      out_ff    <= out_in;
   end

   logic [CntW:0] sum;
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      idx_in     = idx_ff;
      init_in    = init_ff;
      prev_in    = prev_ff;
      largest_in = largest_ff;
      ovf_in     = ovf_ff;
      col_in     = col_ff;
      sel_in     = sel_ff;
      subrow_in  = subrow_ff;
      out_in     = out_ff;
      out_v_in   = out_v_ff && rsp_stall;
      mk_we = 1'b0;
      st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = col_ff;
      cu_we = 1'b0; cu_wa = '0; cu_wd = '0; cu_ra = col_ff[ColW-2:0] - 1'b1;
      sum = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in = req_data;
               idx_in = '0;
               unique case (req_data.operation)
                  OP_CLEAR:  state_in = ST_CLEAR;
                  OP_LOAD:   state_in = ST_DONE;
                  OP_COUNT, OP_PLACE: state_in = ST_MARKS;
                  OP_PREFIX: begin
                     state_in = ST_PREFIX;
                     prev_in = '0;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                     st_ra = ColW'(req_data.column_index);
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MARKS: begin
            // marks ready: decide selection, read start or cursor
            sel_in = r_ok && c_ok && !c_big;
            if (r_ok && c_ok && c_big) ovf_in = 1'b1;
            col_in = ColW'(cprod);
            subrow_in = 10'(rmag - 12'd1);
            st_ra = ColW'(cprod);
            cu_ra = (ColW-1)'(cprod - 14'sd1);
            state_in = ST_ENTRY;
         end
         ST_ENTRY: begin
            out_in = '0;
            out_in.selected = sel_ff;
            if (req_ff.operation == OP_COUNT) begin
               if (sel_ff) begin
                  if (st_rd >= CntW'(MaxEntries)) ovf_in = 1'b1;
                  else begin
                     st_we = 1'b1; st_wa = col_ff; st_wd = st_rd + 1'b1;
                  end
               end
            end else if (sel_ff) begin
               if (cu_rd >= CntW'(MaxEntries)) ovf_in = 1'b1;
               else begin
                  cu_we = 1'b1; cu_wa = col_ff[ColW-2:0] - 1'b1; cu_wd = cu_rd + 1'b1;
                  out_in.slot = SlotW'(cu_rd);
                  out_in.sub_row = subrow_ff;
                  out_in.value_out = req_ff.entry_value;
               end
            end
            out_in.max_column_count = largest_ff;
            out_in.overflow = ovf_in;
            out_v_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            st_we = 1'b1; st_wa = idx_ff[ColW-1:0];
            cu_we = idx_ff < (ColW+1)'(MaxColumns);
            cu_wa = idx_ff[ColW-2:0];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (ColW+1)'(MaxColumns)) begin
               largest_in = '0;
               ovf_in = 1'b0;
               // the sweep after reset gives no result
               state_in = init_ff ? ST_IDLE : ST_DONE;
               init_in = 1'b0;
            end
         end
         ST_PREFIX: begin
            // idx 0: issue read of column 1; idx k>=1: column k data ready
            st_ra = idx_ff[ColW-1:0] + 1'b1;
            if (idx_ff != '0) begin
               sum = {1'b0, st_rd} + {1'b0, prev_ff};
               if (st_rd > largest_ff) largest_in = st_rd;
               cu_we = 1'b1; cu_wa = idx_ff[ColW-2:0] - 1'b1; cu_wd = prev_ff;
               if (sum > (CntW+1)'(MaxEntries)) begin
                  sum = (CntW+1)'(MaxEntries);
                  ovf_in = 1'b1;
               end
               st_we = 1'b1; st_wa = idx_ff[ColW-1:0]; st_wd = sum[CntW-1:0];
               prev_in = sum[CntW-1:0];
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == {1'b0, ncols}) begin
               out_in = '0;
               out_in.start_offset = (idx_ff == '0) ? '0 : sum[CntW-1:0];
               out_in.max_column_count = largest_in;
               out_in.overflow = ovf_in;
               out_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            out_in = '0;
            if (req_ff.column_index <= 11'(MaxColumns)) out_in.start_offset = st_rd;
            out_in.max_column_count = largest_ff;
            out_in.overflow = ovf_ff;
            out_v_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DONE: begin
            mk_we = req_ff.operation == OP_LOAD;
            out_in = '0;
            out_in.max_column_count = largest_ff;
            out_in.overflow = ovf_ff;
            out_v_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[src/scsc_checker.sv]
module scsc_checker
   import scsc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken while busy");
   a_no_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");
   a_place_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.selected |-> rsp_data.slot == '0 && rsp_data.sub_row == '0)
      else $error("slot without selection");
endmodule

bind sparse_csr_to_csc_submatrix_top scsc_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data);

[verif/sparse_csr_to_csc_submatrix_top_tb.sv]
module sparse_csr_to_csc_submatrix_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scsc_pkg::*;

   // operation codes the block must ignore
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   // cycles without any handshake before the run is declared hung
   localparam int HangLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_wdata = '0;

   always #1 clock = ~clock;

   sparse_csr_to_csc_submatrix_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the extractor state
   logic signed [11:0] row_mark_mem [MaxPoints];
   logic signed [11:0] col_mark_mem [MaxPoints];
   logic [12:0]        start_mem [MaxColumns+1];
   logic [12:0]        cursor_mem [MaxColumns];
   logic [12:0]        largest_tally = '0;
   logic               overflow_flag = 1'b0;
   logic signed [1:0]  row_scale_q = 2'sd1;
   logic signed [1:0]  col_scale_q = 2'sd1;
   logic [10:0]        sel_cols_q = '0;

   // points whose marks have been written, the only ones entries may touch
   int      marked_points[$];
   rsp_type pending_rsp[$];
   rsp_type want_rsp;
   bit      failed = 1'b0;
   int      send_gap_pct = 0;
   int      rsp_stall_pct = 0;
   int      quiet_cycles = 0;

   initial begin
      foreach (start_mem[i]) start_mem[i] = '0;
      foreach (cursor_mem[i]) cursor_mem[i] = '0;
   end

   // one-based submatrix column of an entry, zero when not in the submatrix
   function automatic int entry_column(int r, int c, output int row_mag);
      int rm;
      int cm;
      row_mag = 0;
      rm = int'(row_mark_mem[r]);
      if (int'(row_scale_q) * rm <= 0) return 0;
      cm = int'(col_mark_mem[c]) * int'(col_scale_q);
      if (cm <= 0) return 0;
      if (cm > MaxColumns) begin
         overflow_flag = 1'b1;
         return 0;
      end
      row_mag = (rm < 0) ? -rm : rm;
      return cm;
   endfunction

   // advance the shadow state by one item and return its result
   function automatic rsp_type next_result(req_type q);
      rsp_type r;
      int col;
      int mag;
      int n;
      int s;
      int cur;
      r = '0;
      case (q.operation)
         OP_CLEAR: begin
            foreach (start_mem[i]) start_mem[i] = '0;
            foreach (cursor_mem[i]) cursor_mem[i] = '0;
            largest_tally = '0;
            overflow_flag = 1'b0;
         end
         OP_LOAD: begin
            row_mark_mem[q.point] = q.row_mark;
            col_mark_mem[q.point] = q.col_mark;
         end
         OP_COUNT: begin
            col = entry_column(int'(q.entry_row), int'(q.entry_col), mag);
            if (col > 0) begin
               r.selected = 1'b1;
               if (start_mem[col] >= MaxEntries) overflow_flag = 1'b1;
               else start_mem[col] = 13'(start_mem[col] + 1);
            end
         end
         OP_PREFIX: begin
            n = (sel_cols_q > MaxColumns) ? MaxColumns : int'(sel_cols_q);
            for (int i = 1; i <= n; i++) begin
               if (start_mem[i] > largest_tally) largest_tally = start_mem[i];
               cursor_mem[i-1] = start_mem[i-1];
               s = start_mem[i] + start_mem[i-1];
               if (s > MaxEntries) begin
                  s = MaxEntries;
                  overflow_flag = 1'b1;
               end
               start_mem[i] = 13'(s);
            end
            r.start_offset = start_mem[n];
         end
         OP_PLACE: begin
            col = entry_column(int'(q.entry_row), int'(q.entry_col), mag);
            if (col > 0) begin
               r.selected = 1'b1;
               cur = int'(cursor_mem[col-1]);
               if (cur >= MaxEntries) begin
                  overflow_flag = 1'b1;
               end else begin
                  r.slot = 12'(cur);
                  r.sub_row = 10'(mag - 1);
                  r.value_out = q.entry_value;
                  cursor_mem[col-1] = 13'(cur + 1);
               end
            end
         end
         OP_READ: begin
            if (q.column_index <= MaxColumns) r.start_offset = start_mem[q.column_index];
         end
         default: ;
      endcase
      r.max_column_count = largest_tally;
      r.overflow = overflow_flag;
      return r;
   endfunction

   task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s expected %0h actual %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   // result checker and random receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result expected none actual %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            want_rsp = pending_rsp.pop_front();
            report_field("selected", want_rsp.selected, rsp_data.selected);
            report_field("slot", want_rsp.slot, rsp_data.slot);
            report_field("sub_row", want_rsp.sub_row, rsp_data.sub_row);
            report_field("value_out", want_rsp.value_out, rsp_data.value_out);
            report_field("start_offset", want_rsp.start_offset, rsp_data.start_offset);
            report_field("max_column_count", want_rsp.max_column_count,
                         rsp_data.max_column_count);
            report_field("overflow", want_rsp.overflow, rsp_data.overflow);
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // hang detector: any handshake restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // hand one item to the block, with an optional random gap first
   task automatic send_item(req_type q);
      if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp = {pending_rsp, next_result(q)};
   endtask

   // item of the given operation with every other field random
   function automatic req_type random_item(logic [2:0] op);
      req_type q;
      q.operation = op;
      q.point = 10'($urandom);
      q.row_mark = 12'($urandom);
      q.col_mark = 12'($urandom);
      q.entry_row = 10'($urandom);
      q.entry_col = 10'($urandom);
      q.entry_value = {$urandom, $urandom};
      q.column_index = 11'($urandom);
      return q;
   endfunction

   // mostly small marks so columns land inside the prefix range
   function automatic logic signed [11:0] random_mark();
      int mag;
      if ($urandom_range(99) < 85) begin
         mag = $urandom_range(1, 8);
         return 12'($urandom_range(1) ? -mag : mag);
      end
      return 12'($urandom);
   endfunction

   task automatic load_marks(int p, logic signed [11:0] rm, logic signed [11:0] cm);
      req_type q;
      q = random_item(OP_LOAD);
      q.point = 10'(p);
      q.row_mark = rm;
      q.col_mark = cm;
      send_item(q);
      marked_points = {marked_points, p};
   endtask

   task automatic send_entry(logic [2:0] op, int r, int c);
      req_type q;
      q = random_item(op);
      q.entry_row = 10'(r);
      q.entry_col = 10'(c);
      send_item(q);
   endtask

   task automatic read_start(int col);
      req_type q;
      q = random_item(OP_READ);
      q.column_index = 11'(col);
      send_item(q);
   endtask

   task automatic send_op(logic [2:0] op);
      send_item(random_item(op));
   endtask

   // drain all results so registers can be written safely
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [10:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ROW_SCALE: row_scale_q = data[1:0];
         CSR_COL_SCALE: col_scale_q = data[1:0];
         CSR_SEL_COLS:  sel_cols_q = data;
         default: ;
      endcase
   endtask

   // corner marks, huge column range, odd scales, out-of-range reads
   task automatic test_directed();
      write_csr(CSR_ROW_SCALE, {9'h1ff, 2'b01});
      write_csr(CSR_COL_SCALE, 11'd1);
      write_csr(CSR_SEL_COLS, 11'd2047);      // clamps to full column range
      load_marks(0, 12'sd1, 12'sd1);
      load_marks(1023, 12'sh800, 12'sd2047);
      load_marks(5, 12'sd1024, -12'sd1024);
      load_marks(6, 12'sd2047, 12'sd1024);
      send_entry(OP_COUNT, 0, 0);
      send_entry(OP_COUNT, 0, 1023);          // column past range sets overflow
      send_entry(OP_COUNT, 6, 6);             // last legal column
      send_entry(OP_COUNT, 1023, 0);          // negative row mark not taken
      send_op(OP_PREFIX);
      read_start(0);
      read_start(1024);
      read_start(1025);
      read_start(2047);
      send_entry(OP_PLACE, 0, 0);
      send_entry(OP_PLACE, 6, 6);
      send_op(OP_SPARE_A);
      send_op(OP_SPARE_B);
      wait_idle();
      // negative scales pick the negative marks
      write_csr(CSR_ROW_SCALE, 11'h7ff);
      write_csr(CSR_COL_SCALE, 11'h7ff);
      send_entry(OP_COUNT, 1023, 5);
      send_op(OP_PREFIX);
      send_entry(OP_PLACE, 1023, 5);
      wait_idle();
      // scale of -2 and scale of zero
      write_csr(CSR_ROW_SCALE, 11'd2);
      write_csr(CSR_COL_SCALE, 11'd0);
      send_entry(OP_COUNT, 1023, 5);
      send_op(OP_CLEAR);
      wait_idle();
      write_csr(CSR_SEL_COLS, 11'd0);
      send_op(OP_PREFIX);
      wait_idle();
   endtask

   // clear, load marks, count, prefix, place, read back, with some noise
   task automatic test_round(int nloads, int nents);
      int ent_r[$];
      int ent_c[$];
      int k;
      int scale_pick;
      wait_idle();
      scale_pick = $urandom_range(99);
      write_csr(CSR_ROW_SCALE, 11'((scale_pick < 10 ? 11'd0 : (scale_pick < 20 ? 11'd2 :
                ($urandom_range(1) ? 11'd1 : 11'd3))) | ($urandom & 11'h7fc)));
      write_csr(CSR_COL_SCALE, ($urandom_range(99) < 10) ? 11'd2 :
                ($urandom_range(1) ? 11'd1 : 11'd3));
      write_csr(CSR_SEL_COLS, 11'($urandom_range(4, 12)));
      send_op(OP_CLEAR);
      for (int i = 0; i < nloads; i++)
         load_marks($urandom_range(1023), random_mark(), random_mark());
      for (int i = 0; i < nents; i++) begin
         ent_r = {ent_r, marked_points[$urandom_range(marked_points.size() - 1)]};
         ent_c = {ent_c, marked_points[$urandom_range(marked_points.size() - 1)]};
         send_entry(OP_COUNT, ent_r[i], ent_c[i]);
         // occasional noise between counts
         k = $urandom_range(99);
         if (k < 4) read_start($urandom);
         else if (k < 7) send_op($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B);
      end
      send_op(OP_PREFIX);
      for (int i = 0; i < nents; i++) begin
         send_entry(OP_PLACE, ent_r[i], ent_c[i]);
         if ($urandom_range(99) < 5)
            load_marks($urandom_range(1023), random_mark(), random_mark());
      end
      for (int i = 0; i < 4; i++) read_start($urandom_range(14));
   endtask

   task automatic test_random(int gap_pct, int stall_pct);
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < 6; i++) test_round($urandom_range(4, 10), $urandom_range(8, 16));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_gap_pct = 20;
      rsp_stall_pct = 74;
      test_directed();
      test_random(20, 74);
      test_random(74, 20);
      test_random(0, 0);
      wait_idle();
      repeat (20) @(posedge clock);
      if (!failed && pending_rsp.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
